// ----- rtl/radix_integer_to_ascii_core_defines.svh -----
// Assertion macros used by the checker file of the radix integer-to-ASCII core.
// No dependencies; take it in by include before the checker module.
`ifndef RADIX_INTEGER_TO_ASCII_CORE_DEFINES_SVH
`define RADIX_INTEGER_TO_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RITOA_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error("assertion lbl failed");

// Next-cycle implication, disabled while reset is asserted.
`define RITOA_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error("assertion lbl failed");

`endif

// ----- rtl/ritoa_pkg.sv -----
// Types, character constants and the digit-to-ASCII map of the radix integer-to-ASCII core.
// No dependencies.
package ritoa_pkg;

	localparam logic [7:0] ASCII_ZERO      = 8'd48;
	localparam logic [7:0] ASCII_ALPHA_OFF = 8'd87;
	localparam logic [7:0] ASCII_MINUS     = 8'd45;
	localparam logic [7:0] ASCII_NUL       = 8'd0;
	localparam logic [5:0] RADIX_MIN       = 6'd2;
	localparam logic [5:0] RADIX_MAX       = 6'd36;
	localparam int         DIGIT_W         = 6;

	// Result of one division step sequence.
	typedef struct packed {
		logic               done;
		logic [DIGIT_W-1:0] rem;
	} ritoa_div_res_t;

	function automatic logic [7:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [7:0] d8;
		d8 = {2'b00, d};
		if (d > 6'd9) begin
			return ASCII_ALPHA_OFF + d8;
		end
		return ASCII_ZERO + d8;
	endfunction

endpackage

// ----- rtl/ritoa_div.sv -----
// Restoring divider: a VALUE_WIDTH-bit dividend by a 6-bit radix, one quotient bit a cycle.
// Depends on ritoa_pkg.
module ritoa_div
	import ritoa_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [DIGIT_W-1:0]     divisor,
	output logic [VALUE_WIDTH-1:0] quotient,
	output ritoa_div_res_t         res
);

	localparam int CW = $clog2(VALUE_WIDTH + 1);

	logic [DIGIT_W-1:0]     rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [CW-1:0]          bits_q;
	logic                   busy_q;
	logic                   done_q;

	logic [DIGIT_W:0] trial;
	logic             fits;

	// Shift in the next dividend bit and try a subtract.
	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bits_q <= '0;
		end else begin
			// Pulse done for one cycle after the final quotient bit.
			done_q <= busy_q && !start && (bits_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				bits_q <= CW'(VALUE_WIDTH);
			end else if (busy_q) begin
				bits_q <= bits_q - 1'b1;
				if (bits_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DIGIT_W'(trial - {1'b0, divisor}) : trial[DIGIT_W-1:0];
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign res      = '{done: done_q, rem: rem_q};

endmodule

// ----- rtl/ritoa_digit_mem.sv -----
// Digit store: one write port and one registered read port.
// Depends on ritoa_pkg.
module ritoa_digit_mem
	import ritoa_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DIGIT_W-1:0]       wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DIGIT_W-1:0]       rdata
);

	logic [DIGIT_W-1:0] mem [DEPTH];
	logic [DIGIT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/radix_integer_to_ascii_core.sv -----
// Top level of the radix integer-to-ASCII core: sequencer, shared divider and digit store.
// Depends on ritoa_pkg, ritoa_div and ritoa_digit_mem.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | sink      | in_valid / in_stall | value, radix, is_signed
//  out     | source    | out_valid/out_stall | ascii_char, last, bad_radix
//
// Each digit takes one pass through the shared restoring divider (one
// quotient bit a cycle), and once all digits are stored each character
// is read from the digit store and then shown.
// A bad radix answers in one word, offered the cycle after the input word is taken.
// in_stall stays high from acceptance until the last output word is taken.
// Reset is asynchronous and clears the sequencer; the digit store needs no clearing.
// A stalled output word holds; the sequencer waits on it.
module radix_integer_to_ascii_core
	import ritoa_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] value,
	input  logic [5:0]  radix,
	input  logic        is_signed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  ascii_char,
	output logic        last,
	output logic        bad_radix
);

	localparam int CW = $clog2(VALUE_WIDTH + 1);
	localparam int AW = $clog2(VALUE_WIDTH);
	localparam int IW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOAD  = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_SIGN  = 7'b0001000,
		ST_RDREQ = 7'b0010000,
		ST_CHAR  = 7'b0100000,
		ST_ERR   = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [DIGIT_W-1:0]     radix_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          idx_q;
	logic                   sign_q;

	logic [VALUE_WIDTH-1:0] in_val;
	logic [VALUE_WIDTH-1:0] in_mag;
	logic                   in_neg;
	logic                   radix_ok;
	logic                   in_take;
	logic                   out_take;
	logic [CW-1:0]          cnt_next;
	logic                   more_digits;

	logic [VALUE_WIDTH-1:0] div_quo;
	ritoa_div_res_t         div_res;
	logic [DIGIT_W-1:0]     rd_digit;

	// Keep only the low VALUE_WIDTH bits of the input word, zero-extended if wider.
	assign in_val = VALUE_WIDTH'(value[IW-1:0]);
	assign in_neg = is_signed & in_val[VALUE_WIDTH-1];
	assign in_mag = in_neg ? (~in_val + 1'b1) : in_val;

	always_comb begin
		radix_ok = radix inside {[RADIX_MIN:RADIX_MAX]};
	end

	assign in_take  = in_valid && (state_q == ST_IDLE);
	assign out_take = out_valid && !out_stall;

	// Count of stored digits once this one lands; loop while quotient is nonzero and fewer than VALUE_WIDTH are stored.
	assign cnt_next    = cnt_q + 1'b1;
	assign more_digits = (div_quo != '0) && (cnt_next < CW'(VALUE_WIDTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			sign_q  <= 1'b0;
			quo_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (radix_ok) begin
							quo_q   <= in_mag;
							sign_q  <= in_neg;
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_ERR;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_res.done) begin
						quo_q <= div_quo;
						cnt_q <= cnt_next;
						if (more_digits) begin
							state_q <= ST_LOAD;
						end else begin
							// Digits drain from the top entry down.
							idx_q   <= cnt_q;
							state_q <= sign_q ? ST_SIGN : ST_RDREQ;
						end
					end
				end
				ST_SIGN: begin
					if (out_take) begin
						state_q <= ST_RDREQ;
					end
				end
				ST_RDREQ: begin
					state_q <= ST_CHAR;
				end
				ST_CHAR: begin
					if (out_take) begin
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= ST_RDREQ;
						end
					end
				end
				ST_ERR: begin
					if (out_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the radix for the whole conversion.
	always_ff @(posedge clk) begin
		if (in_take) begin
			radix_q <= radix;
		end
	end

	ritoa_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_LOAD),
		.dividend(quo_q),
		.divisor (radix_q),
		.quotient(div_quo),
		.res     (div_res)
	);

	ritoa_digit_mem #(
		.DEPTH(VALUE_WIDTH)
	) u_digits (
		.clk  (clk),
		.we   ((state_q == ST_DIV) && div_res.done),
		.waddr(cnt_q[AW-1:0]),
		.wdata(div_res.rem),
		.re   (state_q == ST_RDREQ),
		.raddr(idx_q[AW-1:0]),
		.rdata(rd_digit)
	);

	// Output word comes straight from registered state and the registered read data.
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_SIGN) || (state_q == ST_CHAR) || (state_q == ST_ERR);

	always_comb begin
		case (state_q)
			ST_SIGN: ascii_char = ASCII_MINUS;
			ST_CHAR: ascii_char = digit_to_ascii(rd_digit);
			default: ascii_char = ASCII_NUL;
		endcase
	end

	assign last      = (state_q == ST_ERR) || ((state_q == ST_CHAR) && (idx_q == '0));
	assign bad_radix = (state_q == ST_ERR);

endmodule

// ----- rtl/ritoa_checker.sv -----
// Port-level assertions for the radix integer-to-ASCII core, bound to the top level.
// Depends on radix_integer_to_ascii_core_defines.svh and radix_integer_to_ascii_core.
`include "radix_integer_to_ascii_core_defines.svh"

module ritoa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] ascii_char,
	input logic       last,
	input logic       bad_radix
);

	`RITOA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`RITOA_ASSERT_NOW(a_no_accept_while_out, clk, arst_n, out_valid, in_stall)
	`RITOA_ASSERT_NOW(a_err_single_word, clk, arst_n, out_valid && bad_radix, last && (ascii_char == 8'd0))
	`RITOA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(ascii_char) && $stable(last))

endmodule

bind radix_integer_to_ascii_core ritoa_checker u_ritoa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.ascii_char(ascii_char),
	.last      (last),
	.bad_radix (bad_radix)
);

// ----- tb/sv/tb_radix_integer_to_ascii_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for radix_integer_to_ascii_core: directed and random numbers in
// bases 0..63, with each character checked against an in-line digit predictor.
// Depends on ritoa_pkg and the core RTL only.
module tb_radix_integer_to_ascii_core;
	import ritoa_pkg::*;

	localparam int RANDOM_NUMBERS = 420;
	// Worst number: radix 2 needs 32 digits, each a full pass of the divider, with no
	// word moving on either side while it converts. Allow several times that.
	localparam int STALL_LIMIT    = 20000;
	localparam int DRAIN_CYCLES   = 100;

	typedef struct packed {
		logic [31:0] value;
		logic [5:0]  radix;
		logic        is_signed;
	} number_t;

	typedef struct packed {
		logic [7:0] ascii_char;
		logic       last;
		logic       bad_radix;
	} char_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] value = '0;
	logic [5:0]  radix = '0;
	logic        is_signed = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  ascii_char;
	logic        last;
	logic        bad_radix;

	number_t    pending_numbers[$];
	char_word_t expected_chars[$];
	int         total_numbers = 0;
	int         numbers_taken = 0;
	int         error_count = 0;
	int         quiet_cycles = 0;

	radix_integer_to_ascii_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.radix     (radix),
		.is_signed (is_signed),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ascii_char(ascii_char),
		.last      (last),
		.bad_radix (bad_radix)
	);

	always #5 clk = ~clk;

	// Work out the characters one number should produce and append them to the
	// expected stream. A bad radix gives a single NUL word flagged as an error.
	task automatic spell_number(input number_t n);
		logic [31:0] mag;
		logic [5:0]  digits [0:31];
		logic [5:0]  d;
		logic        negative;
		int          count;
		if (n.radix < RADIX_MIN || n.radix > RADIX_MAX) begin
			expected_chars.push_back('{ASCII_NUL, 1'b1, 1'b1});
			return;
		end
		negative = n.is_signed && n.value[31];
		// The most negative value negates onto itself, which is its true magnitude.
		mag = negative ? (~n.value + 32'd1) : n.value;
		count = 0;
		do begin
			digits[count] = 6'(mag % {26'd0, n.radix});
			mag = mag / {26'd0, n.radix};
			count++;
		end while (mag != 0 && count < 32);
		if (negative) begin
			expected_chars.push_back('{ASCII_MINUS, 1'b0, 1'b0});
		end
		for (int i = count - 1; i >= 0; i--) begin
			d = digits[i];
			expected_chars.push_back('{(d > 6'd9) ? ASCII_ALPHA_OFF + {2'b00, d}
				: ASCII_ZERO + {2'b00, d}, i == 0, 1'b0});
		end
	endtask

	task automatic queue_number(input logic [31:0] v, input logic [5:0] r, input logic s);
		pending_numbers.push_back('{v, r, s});
	endtask

	// Idle percentages per phase: a quick sender against a busy receiver first,
	// then the reverse, then both sides at full rate.
	function automatic int sender_idle_pct();
		if (numbers_taken < total_numbers / 3) begin
			return 16;
		end
		if (numbers_taken < 2 * total_numbers / 3) begin
			return 79;
		end
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (numbers_taken < total_numbers / 3) begin
			return 79;
		end
		if (numbers_taken < 2 * total_numbers / 3) begin
			return 16;
		end
		return 0;
	endfunction

	// Input driver: predict on acceptance, then present the next word or idle.
	// A stalled word holds its payload until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			value     <= '0;
			radix     <= '0;
			is_signed <= 1'b0;
		end else begin : drive
			number_t n;
			if (in_valid && !in_stall) begin
				spell_number('{value, radix, is_signed});
				numbers_taken <= numbers_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_numbers.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
					n = pending_numbers.pop_front();
					in_valid  <= 1'b1;
					value     <= n.value;
					radix     <= n.radix;
					is_signed <= n.is_signed;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compare each taken word with the oldest expected character,
	// then pick the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin : observe
			char_word_t want;
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected word: expected none, actual char %h last %b bad %b",
						$time, ascii_char, last, bad_radix);
					error_count++;
				end else begin
					want = expected_chars.pop_front();
					if (ascii_char !== want.ascii_char) begin
						$display("%0t: ascii_char mismatch: expected %h, actual %h",
							$time, want.ascii_char, ascii_char);
						error_count++;
					end
					if (last !== want.last) begin
						$display("%0t: last mismatch: expected %b, actual %b",
							$time, want.last, last);
						error_count++;
					end
					if (bad_radix !== want.bad_radix) begin
						$display("%0t: bad_radix mismatch: expected %b, actual %b",
							$time, want.bad_radix, bad_radix);
						error_count++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < receiver_idle_pct());
		end
	end

	// Watchdog: end the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("tb_radix_integer_to_ascii_core: errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		logic [31:0] v;
		logic [5:0]  r;
		int          pick;
		logic [31:0] edges [0:5];
		edges[0] = 32'h0000_0000;
		edges[1] = 32'h8000_0000;
		edges[2] = 32'h7FFF_FFFF;
		edges[3] = 32'hFFFF_FFFF;
		edges[4] = 32'h0000_0001;
		edges[5] = 32'h8000_0001;

		// Zero in both signed modes comes out as a lone '0'.
		queue_number(32'd0, 6'd10, 1'b0);
		queue_number(32'd0, 6'd2, 1'b1);
		// All ones: longest unsigned string, widest base, and -1 when signed.
		queue_number(32'hFFFF_FFFF, 6'd2, 1'b0);
		queue_number(32'hFFFF_FFFF, 6'd36, 1'b0);
		queue_number(32'hFFFF_FFFF, 6'd10, 1'b1);
		// Most negative value signed (minus then the full magnitude), unsigned, and 7FFF_FFFF.
		queue_number(32'h8000_0000, 6'd2, 1'b1);
		queue_number(32'h8000_0000, 6'd10, 1'b1);
		queue_number(32'h8000_0000, 6'd16, 1'b0);
		queue_number(32'h7FFF_FFFF, 6'd36, 1'b1);
		// Bad radix, including with a negative signed value: no minus sign.
		queue_number(32'hFFFF_FF85, 6'd0, 1'b1);
		queue_number(32'd12345, 6'd1, 1'b0);
		queue_number(32'hFFFF_FFFF, 6'd37, 1'b1);
		queue_number(32'd7, 6'd63, 1'b0);
		// Digit to letter boundary and the top letter.
		queue_number(32'd9, 6'd10, 1'b0);
		queue_number(32'd10, 6'd11, 1'b0);
		queue_number(32'd35, 6'd36, 1'b0);
		queue_number(32'd1295, 6'd36, 1'b1);
		// Ordinary bases, positive and negative signed.
		queue_number(32'd59049, 6'd3, 1'b0);
		queue_number(32'o1234567, 6'd8, 1'b1);
		queue_number(32'hDEAD_BEEF, 6'd16, 1'b0);
		queue_number(32'hDEAD_BEEF, 6'd16, 1'b1);
		queue_number(-32'sd987654, 6'd10, 1'b1);
		queue_number(32'd34, 6'd35, 1'b0);

		for (int k = 0; k < RANDOM_NUMBERS; k++) begin
			// Mostly good bases, with a share of every kind of bad one.
			if ($urandom_range(0, 99) < 10) begin
				r = $urandom_range(0, 1) ? 6'($urandom_range(0, 1)) : 6'($urandom_range(37, 63));
			end else begin
				r = 6'($urandom_range(2, 36));
			end
			pick = $urandom_range(0, 3);
			case (pick)
				0: v = $urandom;
				1: v = $urandom_range(0, 1000);
				2: v = -32'($urandom_range(1, 1000));
				default: v = edges[3'($urandom_range(0, 5))];
			endcase
			queue_number(v, r, 1'($urandom_range(0, 1)));
		end
		total_numbers = pending_numbers.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Hold until every number is taken and every character has come back.
		while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0) begin
			@(posedge clk);
		end
		// Let any stray extra words surface before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_radix_integer_to_ascii_core: clean");
		end else begin
			$display("tb_radix_integer_to_ascii_core: errors");
		end
		$finish;
	end

endmodule
